/* hw/rtl/lhn_pkg.sv */
// Shared types and constants of the luma histogram normaliser.
package lhn_pkg;

    localparam int BIN_COUNT      = 256;
    localparam int BIN_BITS       = 8;
    localparam int COUNT_BITS_DEF = 24;
    localparam int OUT_COUNT_BITS = 24;
    localparam int FIFO_DEPTH_DEF = 4;

    localparam logic [15:0] LUMA_WR = 16'd19595;
    localparam logic [15:0] LUMA_WG = 16'd38470;
    localparam logic [15:0] LUMA_WB = 16'd7471;
    localparam logic [7:0]  FULL_SCALE = 8'd255;

    localparam logic [1:0] ACT_ADD   = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [BIN_BITS-1:0] bin;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage

/* hw/rtl/lhn_front.sv */
// Front end: accepts transactions, computes luma and queues decoded operations.
module lhn_front
    import lhn_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         req_valid,
    output logic         req_ready,
    input  logic [1:0]   action,
    input  logic [7:0]   red,
    input  logic [7:0]   green,
    input  logic [7:0]   blue,
    input  logic [7:0]   bin_select,
    input  fifo_status_t fifo_status,
    output logic         push,
    output entry_t       push_entry
);

    logic        st_valid_reg;
    logic [1:0]  action_reg;
    logic [7:0]  sel_reg;
    logic [23:0] prod_r_reg;
    logic [23:0] prod_g_reg;
    logic [23:0] prod_b_reg;
    logic        advance;
    logic        accept;
    logic [24:0] luma_sum;
    logic [8:0]  luma_raw;
    logic [7:0]  luma;

    assign advance   = !st_valid_reg || !fifo_status.full;
    assign req_ready = advance;
    assign accept    = req_valid && req_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            st_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg <= action;
            sel_reg    <= bin_select;
            prod_r_reg <= 24'(red) * 24'(LUMA_WR);
            prod_g_reg <= 24'(green) * 24'(LUMA_WG);
            prod_b_reg <= 24'(blue) * 24'(LUMA_WB);
        end
    end

    always_comb
    begin
        luma_sum = 25'(prod_r_reg) + 25'(prod_g_reg) + 25'(prod_b_reg);
        luma_raw = luma_sum[24:16];
        luma     = luma_raw[8] ? 8'hff : luma_raw[7:0];
        push     = st_valid_reg && !fifo_status.full && (action_reg != ACT_NONE);
        push_entry.op  = OP_ADD;
        push_entry.bin = luma;
        unique case (action_reg)
            ACT_ADD:
            begin
                push_entry.op  = OP_ADD;
                push_entry.bin = luma;
            end
            ACT_READ:
            begin
                push_entry.op  = OP_READ;
                push_entry.bin = sel_reg;
            end
            ACT_CLEAR:
            begin
                push_entry.op  = OP_CLEAR;
                push_entry.bin = sel_reg;
            end
            default:
            begin
                push_entry.op  = OP_ADD;
                push_entry.bin = luma;
            end
        endcase
    end

endmodule

/* hw/rtl/lhn_fifo.sv */
// Short operation queue between front and back.
module lhn_fifo
    import lhn_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  entry_t       push_entry,
    input  logic         pop,
    output entry_t       head,
    output fifo_status_t status
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    entry_t              slot_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic                do_push;
    logic                do_pop;

    assign status.full  = (cnt_reg == CNT_BITS'(DEPTH));
    assign status.empty = (cnt_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

/* hw/rtl/lhn_back.sv */
// Back end: histogram memory, peak tracking and bar height divider.
module lhn_back
    import lhn_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  entry_t                    head,
    input  fifo_status_t              fifo_status,
    output logic                      pop,
    output logic                      rsp_valid,
    input  logic                      rsp_ready,
    output logic [BIN_BITS-1:0]       bin_index,
    output logic [OUT_COUNT_BITS-1:0] bin_count,
    output logic [7:0]                bar_height
);

    localparam int DIV_W = COUNT_BITS + 8;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [4:0] {
        ST_IDLE      = 5'b00001,
        ST_ADD_WR    = 5'b00010,
        ST_READ_DATA = 5'b00100,
        ST_DIV       = 5'b01000,
        ST_OUT       = 5'b10000
    } state_t;

    state_t                state_reg, state_next;
    logic [COUNT_BITS-1:0] mem [BIN_COUNT];
    logic [BIN_COUNT-1:0]  vld_reg;
    logic [COUNT_BITS-1:0] rd_data_reg;
    logic                  rd_vld_reg;
    logic [BIN_BITS-1:0]   bin_reg, bin_next;
    logic [COUNT_BITS-1:0] peak_reg, peak_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]      rem_reg, rem_next;
    logic [7:0]            q_reg, q_next;
    logic [2:0]            step_reg, step_next;
    logic                  out_valid_reg, out_valid_next;
    logic [BIN_BITS-1:0]   out_idx_reg;
    logic [COUNT_BITS-1:0] out_cnt_reg;
    logic [7:0]            out_h_reg;
    logic                  out_load;
    logic                  wr_en;
    logic                  clr;
    logic [COUNT_BITS-1:0] cnt_cur;
    logic [COUNT_BITS-1:0] inc;
    logic [DIV_W-1:0]      cnt_ext;
    logic [DIV_W-1:0]      dividend;
    logic [DIV_W-1:0]      peak_ext;
    logic [DIV_W-1:0]      trial;
    logic [COUNT_BITS+OUT_COUNT_BITS-1:0] cnt_wide;

    assign pop = (state_reg == ST_IDLE) && !fifo_status.empty;

    always_comb
    begin
        cnt_cur  = rd_vld_reg ? rd_data_reg : '0;
        inc      = (cnt_cur == COUNT_MAX) ? cnt_cur : cnt_cur + 1'b1;
        cnt_ext  = DIV_W'(cnt_cur);
        dividend = (cnt_ext << 8) - cnt_ext;
        peak_ext = DIV_W'(peak_reg);
        trial    = peak_ext << step_reg;

        state_next = state_reg;
        bin_next   = bin_reg;
        peak_next  = peak_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        step_next  = step_reg;
        out_load   = 1'b0;
        wr_en      = 1'b0;
        clr        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    bin_next = head.bin;
                    unique case (head.op)
                        OP_ADD:   state_next = ST_ADD_WR;
                        OP_READ:  state_next = ST_READ_DATA;
                        OP_CLEAR:
                        begin
                            clr       = 1'b1;
                            peak_next = '0;
                        end
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ADD_WR:
            begin
                wr_en = 1'b1;
                if (inc > peak_reg)
                begin
                    peak_next = inc;
                end
                state_next = ST_IDLE;
            end
            ST_READ_DATA:
            begin
                cnt_next = cnt_cur;
                q_next   = '0;
                if (peak_reg == '0)
                begin
                    state_next = ST_OUT;
                end
                else if (dividend >= (peak_ext << 8))
                begin
                    q_next     = FULL_SCALE;
                    state_next = ST_OUT;
                end
                else
                begin
                    rem_next   = dividend;
                    step_next  = 3'd7;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (rem_reg >= trial)
                begin
                    rem_next         = rem_reg - trial;
                    q_next[step_reg] = 1'b1;
                end
                if (step_reg == 3'd0)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            peak_reg      <= '0;
            vld_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            peak_reg      <= peak_next;
            out_valid_reg <= out_valid_next;
            rd_vld_reg    <= vld_reg[head.bin];
            if (clr)
            begin
                vld_reg <= '0;
            end
            else if (wr_en)
            begin
                vld_reg[bin_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[bin_reg] <= inc;
        end
        rd_data_reg <= mem[head.bin];
    end

    always_ff @(posedge clk)
    begin
        bin_reg  <= bin_next;
        cnt_reg  <= cnt_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        step_reg <= step_next;
        if (out_load)
        begin
            out_idx_reg <= bin_reg;
            out_cnt_reg <= cnt_reg;
            out_h_reg   <= q_reg;
        end
    end

    assign cnt_wide   = {{OUT_COUNT_BITS{1'b0}}, out_cnt_reg};
    assign rsp_valid  = out_valid_reg;
    assign bin_index  = out_idx_reg;
    assign bin_count  = cnt_wide[OUT_COUNT_BITS-1:0];
    assign bar_height = out_h_reg;

    a_clear_zeroes_peak: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head.op == OP_CLEAR) |=> (peak_reg == '0))
        else $error("peak not cleared");

    a_peak_tracks_add: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADD_WR) |=> (peak_reg >= $past(inc)))
        else $error("peak below updated bin");

    a_div_remainder: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < (peak_ext << ({1'b0, step_reg} + 4'd1))))
        else $error("divider remainder out of range");

    a_out_from_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result loaded outside output state");

endmodule

/* hw/rtl/luma_histogram_normalizer.sv */
// Top level of the luma histogram normaliser.
//
// Request channel (req_valid/req_ready): action, red, green, blue, bin_select.
//   Add: luma of the pixel increments its bin (saturating) and the peak.
//   Read: returns bin_index, bin_count and bar_height = count*255/peak.
//   Clear: zeroes all bins and the peak. Action code 3 is dropped.
// Response channel (rsp_valid/rsp_ready): one transaction per read only.
// The front stage registers the luma products and queues the operation; the
// back end executes one operation at a time against the histogram memory.
// The back end takes each add through a write state for the memory
// read-modify-write and completes a clear in its idle state; a read passes
// through the 8-step restoring divider, which is skipped when the peak is
// zero or the result saturates.
// Reset clears the queue, all bin valid bits and the peak at once, so the
// histogram reads as empty straight after reset with no clearing pass.
// A stalled response holds its register; the queue keeps accepting requests
// until it fills, after which req_ready drops.
module luma_histogram_normalizer
    import lhn_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_ready,
    input  logic [1:0]                action,
    input  logic [7:0]                red,
    input  logic [7:0]                green,
    input  logic [7:0]                blue,
    input  logic [7:0]                bin_select,
    output logic                      rsp_valid,
    input  logic                      rsp_ready,
    output logic [BIN_BITS-1:0]       bin_index,
    output logic [OUT_COUNT_BITS-1:0] bin_count,
    output logic [7:0]                bar_height
);

    fifo_status_t fifo_status;
    logic         push;
    entry_t       push_entry;
    logic         pop;
    entry_t       head;

    lhn_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .action      (action),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .bin_select  (bin_select),
        .fifo_status (fifo_status),
        .push        (push),
        .push_entry  (push_entry)
    );

    lhn_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (fifo_status)
    );

    lhn_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .fifo_status (fifo_status),
        .pop         (pop),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .bin_index   (bin_index),
        .bin_count   (bin_count),
        .bar_height  (bar_height)
    );

endmodule

/* verif/tb.sv */
// Self-checking testbench for the luma histogram normaliser.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lhn_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 20;

    typedef struct {
        logic [BIN_BITS-1:0]       idx;
        logic [OUT_COUNT_BITS-1:0] count;
        logic [7:0]                height;
    } bin_report_t;

    logic                      clk        = 1'b0;
    logic                      rst_n      = 1'b0;
    logic                      req_valid  = 1'b0;
    logic                      req_ready;
    logic [1:0]                action     = ACT_ADD;
    logic [7:0]                red        = '0;
    logic [7:0]                green      = '0;
    logic [7:0]                blue       = '0;
    logic [7:0]                bin_select = '0;
    logic                      rsp_valid;
    logic                      rsp_ready  = 1'b0;
    logic [BIN_BITS-1:0]       bin_index;
    logic [OUT_COUNT_BITS-1:0] bin_count;
    logic [7:0]                bar_height;

    logic [COUNT_BITS_DEF-1:0] hist_bins [BIN_COUNT] = '{default: '0};
    logic [COUNT_BITS_DEF-1:0] peak_count = '0;
    bin_report_t               pending_reads [$];

    int   mismatches   = 0;
    int   quiet_cycles = 0;
    int   stall_left   = 0;
    logic bursts_on    = 1'b0;
    logic idle_enabled = 1'b1;

    luma_histogram_normalizer uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .action     (action),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .bin_select (bin_select),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .bin_index  (bin_index),
        .bin_count  (bin_count),
        .bar_height (bar_height)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [7:0] luma_bin(input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b);
        logic [31:0] sum;
        logic [31:0] y;
        begin
            sum = 32'(LUMA_WR) * 32'(r) + 32'(LUMA_WG) * 32'(g) + 32'(LUMA_WB) * 32'(b);
            y = sum >> 16;
            if (y > 32'd255)
            begin
                y = 32'd255;
            end
            return y[7:0];
        end
    endfunction

    // Histogram state follows each accepted transaction in order.
    function automatic void histogram_update(input logic [1:0] act, input logic [7:0] r,
                                             input logic [7:0] g, input logic [7:0] b,
                                             input logic [7:0] sel);
        logic [7:0]                y;
        logic [COUNT_BITS_DEF-1:0] c;
        logic [63:0]               h;
        bin_report_t               rep;
        begin
            case (act)
                ACT_ADD:
                begin
                    y = luma_bin(r, g, b);
                    c = hist_bins[y];
                    if (c != '1)
                    begin
                        c = c + 1'b1;
                    end
                    hist_bins[y] = c;
                    if (c > peak_count)
                    begin
                        peak_count = c;
                    end
                end
                ACT_READ:
                begin
                    c = hist_bins[sel];
                    h = '0;
                    if (peak_count != '0)
                    begin
                        h = (64'(c) * 64'(FULL_SCALE)) / 64'(peak_count);
                        if (h > 64'(FULL_SCALE))
                        begin
                            h = 64'(FULL_SCALE);
                        end
                    end
                    rep.idx    = sel;
                    rep.count  = c[OUT_COUNT_BITS-1:0];
                    rep.height = h[7:0];
                    pending_reads.push_back(rep);
                end
                ACT_CLEAR:
                begin
                    foreach (hist_bins[i])
                    begin
                        hist_bins[i] = '0;
                    end
                    peak_count = '0;
                end
                default:
                begin
                end
            endcase
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && req_valid && req_ready)
        begin
            histogram_update(action, red, green, blue, bin_select);
        end
    end

    always @(posedge clk)
    begin
        bin_report_t exp_rep;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_reads.size() == 0)
            begin
                $error("unexpected response: bin_index %0d bin_count %0d bar_height %0d",
                       bin_index, bin_count, bar_height);
                mismatches++;
            end
            else
            begin
                exp_rep = pending_reads.pop_front();
                if (bin_index !== exp_rep.idx)
                begin
                    $error("bin_index: expected %0d, got %0d", exp_rep.idx, bin_index);
                    mismatches++;
                end
                if (bin_count !== exp_rep.count)
                begin
                    $error("bin_count: expected %0d, got %0d", exp_rep.count, bin_count);
                    mismatches++;
                end
                if (bar_height !== exp_rep.height)
                begin
                    $error("bar_height: expected %0d, got %0d", exp_rep.height, bar_height);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Response back-pressure in bursts.
    always @(negedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left--;
            rsp_ready <= 1'b0;
        end
        else if (bursts_on && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(1, 16) - 1;
            rsp_ready <= 1'b0;
        end
        else
        begin
            rsp_ready <= 1'b1;
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_req(input logic [1:0] act, input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b, input logic [7:0] sel);
        int gap;
        begin
            gap = 0;
            if (bursts_on && $urandom_range(0, 5) == 0)
            begin
                gap = $urandom_range(1, 16);
            end
            if (gap != 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            req_valid  <= 1'b1;
            action     <= act;
            red        <= r;
            green      <= g;
            blue       <= b;
            bin_select <= sel;
            @(posedge clk);
            while (!req_ready)
            begin
                @(posedge clk);
            end
            @(negedge clk);
        end
    endtask

    task automatic send_add(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        send_req(ACT_ADD, r, g, b, 8'($urandom));
    endtask

    task automatic send_read(input logic [7:0] sel);
        send_req(ACT_READ, 8'($urandom), 8'($urandom), 8'($urandom), sel);
    endtask

    task automatic send_clear();
        send_req(ACT_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic send_noise();
        send_req(ACT_NONE, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic wait_reads_drained();
        begin
            req_valid <= 1'b0;
            @(negedge clk);
            while (pending_reads.size() != 0)
            begin
                @(negedge clk);
            end
        end
    endtask

    task automatic test_empty_histogram();
        begin
            bursts_on = 1'b0;
            send_read(8'h00);
            send_read(8'hFF);
            send_read(8'h55);
            send_read(8'hAA);
        end
    endtask

    // Black, white and the pure primaries, then their bins and an empty one.
    task automatic test_pixel_extremes();
        begin
            bursts_on = 1'b1;
            send_add(8'h00, 8'h00, 8'h00);
            send_add(8'hFF, 8'hFF, 8'hFF);
            send_add(8'hFF, 8'h00, 8'h00);
            send_add(8'h00, 8'hFF, 8'h00);
            send_add(8'h00, 8'h00, 8'hFF);
            send_add(8'hFF, 8'hFF, 8'hFF);
            send_read(luma_bin(8'h00, 8'h00, 8'h00));
            send_read(luma_bin(8'hFF, 8'hFF, 8'hFF));
            send_read(luma_bin(8'hFF, 8'h00, 8'h00));
            send_read(luma_bin(8'h00, 8'hFF, 8'h00));
            send_read(luma_bin(8'h00, 8'h00, 8'hFF));
            send_read(8'd200);
        end
    endtask

    task automatic test_unused_action();
        begin
            send_noise();
            send_noise();
            send_read(8'hFF);
        end
    endtask

    task automatic test_clear_all();
        begin
            send_clear();
            send_read(8'hFF);
            send_add(8'hFF, 8'hFF, 8'hFF);
            send_read(8'hFF);
            send_read(8'h00);
        end
    endtask

    // Bursts of pixels from a small palette build up peaks; reads mostly hit live bins.
    task automatic test_random_traffic(input int n_items);
        logic [7:0] pal_r [8];
        logic [7:0] pal_g [8];
        logic [7:0] pal_b [8];
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] last_bin;
        int         sent;
        int         kind;
        int         n_add;
        int         p;
        begin
            foreach (pal_r[i])
            begin
                pal_r[i] = 8'($urandom);
                pal_g[i] = 8'($urandom);
                pal_b[i] = 8'($urandom);
            end
            sent = 0;
            last_bin = '0;
            bursts_on = idle_enabled;
            while (sent < n_items)
            begin
                if ($urandom_range(0, 31) == 0)
                begin
                    bursts_on = idle_enabled && !bursts_on;
                end
                kind = $urandom_range(0, 19);
                if (kind < 11)
                begin
                    n_add = $urandom_range(1, 10);
                    repeat (n_add)
                    begin
                        p = $urandom_range(0, 7);
                        if ($urandom_range(0, 2) != 0)
                        begin
                            r = pal_r[p];
                            g = pal_g[p];
                            b = pal_b[p];
                        end
                        else
                        begin
                            r = 8'($urandom);
                            g = 8'($urandom);
                            b = 8'($urandom);
                        end
                        send_add(r, g, b);
                        last_bin = luma_bin(r, g, b);
                        sent++;
                    end
                end
                else if (kind < 18)
                begin
                    if ($urandom_range(0, 1) == 0)
                    begin
                        send_read(last_bin);
                    end
                    else if ($urandom_range(0, 1) == 0)
                    begin
                        p = $urandom_range(0, 7);
                        send_read(luma_bin(pal_r[p], pal_g[p], pal_b[p]));
                    end
                    else
                    begin
                        send_read(8'($urandom));
                    end
                    sent++;
                end
                else if (kind == 18)
                begin
                    if ($urandom_range(0, 3) == 0)
                    begin
                        send_clear();
                    end
                    else
                    begin
                        send_read(8'($urandom));
                    end
                    sent++;
                end
                else
                begin
                    send_noise();
                end
            end
        end
    endtask

    task automatic test_results_drain();
        begin
            wait_reads_drained();
            send_read(8'($urandom));
            send_read(8'($urandom));
            wait_reads_drained();
        end
    endtask

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_histogram();
        test_pixel_extremes();
        test_unused_action();
        test_clear_all();
        test_random_traffic(400);
        test_results_drain();
        test_random_traffic(350);
        idle_enabled = 1'b0;
        test_random_traffic(150);

        wait_reads_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatches == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
